>>> rtl/core/lkc_pkg.sv
// Package for the log keyword classifier: window types, keyword table, category codes.
`default_nettype none

package lkc_pkg;

  localparam int HIST_LEN = 13;
  localparam int WIN_LEN  = HIST_LEN + 1;
  localparam int KW_COUNT = 9;
  localparam int GRP_COUNT = 4;

  typedef logic [7:0] byte_t;
  typedef logic [HIST_LEN-1:0][7:0] hist_t;
  // Element 0 is the newest byte, element WIN_LEN-1 the oldest.
  typedef logic [WIN_LEN-1:0][7:0] win_t;
  typedef logic [GRP_COUNT-1:0] groups_t;

  typedef enum logic [2:0] {
    CAT_AUTH    = 3'd0,
    CAT_KERNEL  = 3'd1,
    CAT_NETWORK = 3'd2,
    CAT_STORAGE = 3'd3,
    CAT_SYSTEM  = 3'd4
  } category_t;

  typedef enum logic [1:0] {
    GRP_AUTH    = 2'd0,
    GRP_KERNEL  = 2'd1,
    GRP_NETWORK = 2'd2,
    GRP_STORAGE = 2'd3
  } group_t;

  // Keyword text is right-aligned, so its last character sits in byte 0.
  localparam win_t KW_TEXT [KW_COUNT] = '{
    win_t'("sudo"),
    win_t'("authentication"),
    win_t'("login"),
    win_t'("password"),
    win_t'("kernel"),
    win_t'("network"),
    win_t'("connection"),
    win_t'("disk"),
    win_t'("filesystem")
  };

  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd4, 4'd14, 4'd5, 4'd8, 4'd6, 4'd7, 4'd10, 4'd4, 4'd10
  };

  localparam group_t KW_GROUP [KW_COUNT] = '{
    GRP_AUTH, GRP_AUTH, GRP_AUTH, GRP_AUTH,
    GRP_KERNEL,
    GRP_NETWORK, GRP_NETWORK,
    GRP_STORAGE, GRP_STORAGE
  };

  // ASCII upper case folds to lower case; everything else passes unchanged.
  function automatic byte_t fold_byte(input byte_t b);
    if (b >= 8'h41 && b <= 8'h5A) begin
      return b + 8'd32;
    end
    return b;
  endfunction

  // Groups of every keyword that ends at the newest byte of the window.
  function automatic groups_t keyword_groups(input win_t win);
    groups_t grp;
    logic    hit;
    grp = '0;
    for (int k = 0; k < KW_COUNT; k++) begin
      hit = 1'b1;
      for (int j = 0; j < WIN_LEN; j++) begin
        if (j < int'(KW_LEN[k]) && win[j] != KW_TEXT[k][j]) begin
          hit = 1'b0;
        end
      end
      if (hit) begin
        grp[KW_GROUP[k]] = 1'b1;
      end
    end
    return grp;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/log_keyword_classifier.sv
// Top level of the log keyword classifier: byte window, group flags and result register.
`default_nettype none

// The block takes a log message one byte per transaction, folds ASCII upper case to
// lower case and compares the last fourteen bytes against nine fixed keywords in
// parallel. Each keyword belongs to one of four groups (auth, kernel, network,
// storage), and a match sets that group's sticky flag. On the byte marked as the
// end of the message, one result transaction carries the category code of the
// first flagged group in the order auth, kernel, network, storage, or system when
// none is flagged; the window and the flags are then cleared so that no keyword
// spans two messages. Bytes that are not the last give no result. Throughput is
// one byte per clock cycle: the keyword compares sit between the window registers
// and the result register, and the result register lets a new byte in while a
// finished code is being taken by the consumer. A result appears in the cycle
// after its final byte is accepted. The input stalls only while a code is held
// and the consumer is not ready.
module log_keyword_classifier
  import lkc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_msg_byte,
  input  wire logic       in_end_of_message,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [2:0]      out_category_code
);

  hist_t     recent_r, recent_nxt;
  groups_t   flags_r, flags_nxt;
  logic      out_valid_r, out_valid_nxt;
  category_t code_r, code_nxt;

  byte_t     cur_byte;
  win_t      window;
  groups_t   flags_all;
  logic      in_fire;

  // A new byte is taken whenever the result register is empty or being emptied.
  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  assign cur_byte  = fold_byte(in_msg_byte);
  assign window    = {recent_r, cur_byte};
  assign flags_all = flags_r | keyword_groups(window);

  always_comb begin
    priority if (flags_all[GRP_AUTH]) begin
      code_nxt = CAT_AUTH;
    end else if (flags_all[GRP_KERNEL]) begin
      code_nxt = CAT_KERNEL;
    end else if (flags_all[GRP_NETWORK]) begin
      code_nxt = CAT_NETWORK;
    end else if (flags_all[GRP_STORAGE]) begin
      code_nxt = CAT_STORAGE;
    end else begin
      code_nxt = CAT_SYSTEM;
    end
  end

  always_comb begin
    recent_nxt    = recent_r;
    flags_nxt     = flags_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (in_fire) begin
      if (in_end_of_message) begin
        // The message is complete: start the next one from a clean window.
        recent_nxt    = '0;
        flags_nxt     = '0;
        out_valid_nxt = 1'b1;
      end else begin
        recent_nxt = {recent_r[HIST_LEN-2:0], cur_byte};
        flags_nxt  = flags_all;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      recent_r    <= '0;
      flags_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      recent_r    <= recent_nxt;
      flags_r     <= flags_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // The code register needs no reset; it is only read while the valid flag is set.
  always_ff @(posedge clk) begin
    if (in_fire && in_end_of_message) begin
      code_r <= code_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_category_code = code_r;

`ifndef SYNTH
  // The final byte of a message always produces a result in the next cycle.
  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_end_of_message) |=> out_valid_r)
    else $error("final byte accepted without a result transaction");

  // After a message ends, the window and the group flags start from zero.
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_end_of_message) |=> (recent_r == '0 && flags_r == '0))
    else $error("window or flags not cleared after the end of a message");

  // The input stalls only behind a held result.
  a_stall_reason: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid_r && !out_ready))
    else $error("input stalled without a pending result");

  // A delivered code always lies in the defined range.
  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (code_r <= CAT_SYSTEM))
    else $error("category code out of range");
`endif

endmodule

`default_nettype wire

>>> sim/tb.sv
// Self-checking testbench for the log keyword classifier: message stimulus, category scoreboard.
`timescale 1ns / 1ps

module tb;
  import lkc_pkg::*;

  // Category scoreboard. It keeps its own copy of the byte history and the sticky
  // group flags. Every accepted byte is folded and compared against the keyword
  // list, and every final byte queues the category code that the block should
  // produce. Result transactions are then checked in order against that queue.
  class category_scoreboard;
    string     words [KW_COUNT];
    group_t    word_group [KW_COUNT];
    byte_t     history [HIST_LEN];
    groups_t   flags;
    category_t pending_codes [$];
    int        mismatches;
    int        bytes_seen;
    int        code_count [5];

    function new();
      words = '{"sudo", "authentication", "login", "password", "kernel",
                "network", "connection", "disk", "filesystem"};
      word_group = '{GRP_AUTH, GRP_AUTH, GRP_AUTH, GRP_AUTH, GRP_KERNEL,
                     GRP_NETWORK, GRP_NETWORK, GRP_STORAGE, GRP_STORAGE};
      foreach (history[i]) history[i] = 8'h00;
      foreach (code_count[i]) code_count[i] = 0;
      flags = '0;
      mismatches = 0;
      bytes_seen = 0;
    endfunction

    // Called for every accepted input transaction.
    function void note_byte(byte_t raw, logic last);
      byte_t     window [WIN_LEN];
      byte_t     folded;
      bit        hit;
      int        wl;
      category_t code;
      bytes_seen++;
      folded = (raw >= 8'h41 && raw <= 8'h5A) ? raw + 8'd32 : raw;
      // Element 0 is the byte just accepted, element 1 the newest stored one.
      window[0] = folded;
      for (int i = 0; i < HIST_LEN; i++) window[i + 1] = history[i];
      for (int k = 0; k < KW_COUNT; k++) begin
        wl = words[k].len();
        hit = 1'b1;
        for (int i = 0; i < wl; i++) begin
          if (window[wl - 1 - i] != byte_t'(words[k][i])) hit = 1'b0;
        end
        if (hit) flags[word_group[k]] = 1'b1;
      end
      if (!last) begin
        for (int i = HIST_LEN - 1; i > 0; i--) history[i] = history[i - 1];
        history[0] = folded;
      end else begin
        if (flags[GRP_AUTH]) code = CAT_AUTH;
        else if (flags[GRP_KERNEL]) code = CAT_KERNEL;
        else if (flags[GRP_NETWORK]) code = CAT_NETWORK;
        else if (flags[GRP_STORAGE]) code = CAT_STORAGE;
        else code = CAT_SYSTEM;
        pending_codes = {pending_codes, code};
        foreach (history[i]) history[i] = 8'h00;
        flags = '0;
      end
    endfunction

    // Called for every accepted result transaction.
    function void check_code(logic [2:0] got);
      category_t want;
      if (pending_codes.size() == 0) begin
        $error("category_code: result with no message pending, expected none, actual %0d",
               got);
        mismatches++;
      end else begin
        want = pending_codes.pop_front();
        code_count[want]++;
        if (got !== want) begin
          $error("category_code: expected %0d, actual %0d", want, got);
          mismatches++;
        end
      end
    endfunction
  endclass

  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD   = 400;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_msg_byte = 8'h00;
  logic       in_end_of_message = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [2:0] out_category_code;

  category_scoreboard sb;
  byte_t       msg_q [$];
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int unsigned hold_tickets = 0;
  int unsigned cycle_count = 0;
  int          messages_sent = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  log_keyword_classifier DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_msg_byte       (in_msg_byte),
    .in_end_of_message (in_end_of_message),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_category_code (out_category_code)
  );

  // Guard against a hung handshake. The limit leaves a wide margin over the
  // slowest correct run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  // Both channels are observed at the clock edge, where the values seen are the
  // ones that were present just before it. The input is noted before the result
  // is checked so that the ordering within the step does not matter.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_byte(in_msg_byte, in_end_of_message);
      if (out_valid && out_ready) sb.check_code(out_category_code);
    end
  end

  // Result consumer. It stalls at the current rate, and whenever a long hold is
  // requested it keeps ready low for a fixed stretch, counted here, so that the
  // block fills up and has to back-pressure its input.
  initial begin : result_sink
    int unsigned holds_done;
    holds_done = 0;
    forever begin
      @(posedge clk);
      if (holds_done != hold_tickets) begin
        holds_done++;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      out_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end
  end

  // Offers one byte and returns at the edge where it is accepted. Valid is only
  // lowered when the sender decides to idle, never while a byte is pending.
  task automatic send_byte(byte_t b, logic last);
    if (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99, 0) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_msg_byte <= b;
    in_end_of_message <= last;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_message();
    for (int i = 0; i < msg_q.size(); i++) send_byte(msg_q[i], i == msg_q.size() - 1);
    messages_sent++;
  endtask

  // Adds one byte to the end of the message being built.
  function automatic void append_byte(byte_t b);
    msg_q = {msg_q, b};
  endfunction

  task automatic send_text(string s);
    msg_q.delete();
    for (int i = 0; i < s.len(); i++) append_byte(byte_t'(s[i]));
    send_message();
  endtask

  // Lowers valid after the last transaction of a phase and waits for every
  // outstanding code to come back. The first edge lets the monitor note the
  // final byte before the queue is looked at.
  task automatic finish_phase();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_codes.size() != 0) @(posedge clk);
  endtask

  function automatic byte_t vary_case(byte_t c);
    if (c >= 8'h61 && c <= 8'h7A && $urandom_range(1, 0) == 1) return c - 8'd32;
    return c;
  endfunction

  // Appends a keyword in random letter case. A broken keyword loses one letter.
  function automatic void add_word(string w, bit broken);
    int skip;
    skip = broken ? $urandom_range(w.len() - 1, 0) : -1;
    for (int i = 0; i < w.len(); i++) begin
      if (i != skip) append_byte(vary_case(byte_t'(w[i])));
    end
  endfunction

  // Mostly keywords and letters so that the window matches often and the
  // priority is exercised; the rest is raw noise over the whole byte range.
  function automatic void build_random_message();
    int pick;
    msg_q.delete();
    if ($urandom_range(9, 0) == 0) begin
      repeat ($urandom_range(20, 1)) append_byte(byte_t'($urandom_range(255, 0)));
    end else begin
      repeat ($urandom_range(4, 1)) begin
        pick = $urandom_range(99, 0);
        if (pick < 45) begin
          add_word(sb.words[$urandom_range(KW_COUNT - 1, 0)], 1'b0);
        end else if (pick < 60) begin
          add_word(sb.words[$urandom_range(KW_COUNT - 1, 0)], 1'b1);
        end else if (pick < 85) begin
          repeat ($urandom_range(3, 1))
            append_byte(vary_case(byte_t'(8'h61 + $urandom_range(25, 0))));
        end else begin
          append_byte(byte_t'($urandom_range(255, 0)));
        end
      end
    end
  endfunction

  task automatic run_phase(int idle_pct, int stall_pct, int byte_budget);
    int sent;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < byte_budget) begin
      build_random_message();
      send_message();
      sent += msg_q.size();
    end
    finish_phase();
  endtask

  initial begin : stimulus
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed messages with no idling: every keyword in each group, case
    // folding, the full fourteen byte window, priority between groups, one-byte
    // messages at both byte extremes, and keywords broken by a zero byte, by a
    // byte above 127 and by a message boundary.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    msg_q = '{8'h00};
    send_message();
    msg_q = '{8'hFF};
    send_message();
    send_text("SUDO");
    send_text("AUTHENTICATION");
    send_text("Login");
    send_text("password");
    send_text("kernel");
    send_text("NetWork");
    send_text("connection");
    send_text("Disk");
    send_text("filesystem");
    send_text("disk kernel network sudo");
    send_text("disk network");
    send_text("disk kernel");
    send_text("ker");
    send_text("nel");
    msg_q.delete();
    add_word("ker", 1'b0);
    append_byte(8'h00);
    add_word("nel", 1'b0);
    send_message();
    msg_q.delete();
    add_word("dis", 1'b0);
    append_byte(8'hEB);
    send_message();
    send_text("@[`{AZaz");
    finish_phase();

    // Random messages under each idling pattern in turn.
    run_phase(0, 0, 80);
    run_phase(74, 0, 80);
    run_phase(0, 74, 80);
    run_phase(27, 27, 80);

    // Back-pressure: the consumer holds off for a long stretch while short
    // messages keep arriving, so the held code blocks the input.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_tickets++;
    repeat (15) begin
      msg_q.delete();
      repeat ($urandom_range(4, 1)) append_byte(byte_t'($urandom_range(255, 0)));
      send_message();
    end
    finish_phase();
    repeat (8) @(posedge clk);

    $display("Run covered %0d bytes in %0d messages with idling, stalls and a long hold.",
             sb.bytes_seen, messages_sent);
    $display("Codes checked: auth %0d, kernel %0d, network %0d, storage %0d, system %0d.",
             sb.code_count[CAT_AUTH], sb.code_count[CAT_KERNEL], sb.code_count[CAT_NETWORK],
             sb.code_count[CAT_STORAGE], sb.code_count[CAT_SYSTEM]);
    if (sb.mismatches == 0 && sb.pending_codes.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
